### src/gfpp_pkg.sv
// ---------------------------------------------------------------------------
// gfpp_pkg: shared types and codes for the GIF frame pixel placer
// Request and result payloads, request kinds and configuration indexes.
// ---------------------------------------------------------------------------
package gfpp_pkg;

  // request kinds carried in req_type
  typedef enum logic [1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_PALETTE = 2'd1,
    REQ_START   = 2'd2
  } req_kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH      = 3'd0,
    REG_SCREEN_HEIGHT     = 3'd1,
    REG_IMAGE_LEFT        = 3'd2,
    REG_IMAGE_TOP         = 3'd3,
    REG_IMAGE_WIDTH       = 3'd4,
    REG_TRANSPARENT_INDEX = 3'd5,
    REG_PALETTE_SIZE      = 3'd6
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // transparency disabled after reset
  localparam logic [8:0] TRANSPARENT_NONE = 9'd256;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] color_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } req_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] pixel_address;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [7:0]  pixel_alpha;
  } res_t;

endpackage

### src/gfpp_if.sv
// ---------------------------------------------------------------------------
// gfpp_req_if / gfpp_res_if: valid/ready channels of the pixel placer
// One interface per direction, each carrying a packed payload struct.
// ---------------------------------------------------------------------------
interface gfpp_req_if;
  import gfpp_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gfpp_res_if;
  import gfpp_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/gfpp_palette.sv
// ---------------------------------------------------------------------------
// gfpp_palette: colour palette memory
// One write port, one registered read port; a write at the same edge as a
// read of the same entry is forwarded to the read data.
// ---------------------------------------------------------------------------
module gfpp_palette #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gfpp_pkg::rgb_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gfpp_pkg::rgb_t           rd_data
);
  import gfpp_pkg::*;

  rgb_t mem [DEPTH];
  rgb_t rd_mem;
  rgb_t byp_data;
  logic byp;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port with write forwarding, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mem   <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_mem;

endmodule

### src/gif_frame_pixel_placer.sv
// ---------------------------------------------------------------------------
// gif_frame_pixel_placer: places GIF colour indexes into a frame buffer
// Palette loads, image start and per-pixel address/colour generation with
// raster wrap, screen-full drop and transparency.
// ---------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  req       in   valid / ready     req_type, color_index, entry_red/green/blue
//  res       out  valid / ready     write_enable, pixel_address, pixel_r/g/b/a
//  cfg       in   cfg_we            cfg_index, cfg_data (no read-back)
//
//  One transaction per cycle while results are taken; a request passes the input
//  stage (with palette read), then the result register.
//  The raster loop keeps a running row base (row * screen width), so the
//  per-pixel path is one add and one compare; products of the configuration
//  are registered in the cycle after a write.
//  Synchronous reset clears the cursor, both stages and the registers; the
//  palette is not cleared. A stalled result holds the input stage, and ready
//  drops only when both stages are full.
// ---------------------------------------------------------------------------
module gif_frame_pixel_placer #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gfpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gfpp_pkg::CFG_DATA_W-1:0]     cfg_data,
  gfpp_req_if.sink                            req,
  gfpp_res_if.source                          res
);
  import gfpp_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

  // configuration registers
  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic [15:0] image_left;
  logic [15:0] image_top;
  logic [15:0] image_width;
  logic [8:0]  transparent_index;
  logic [8:0]  palette_size;

  // products of the configuration, refreshed every cycle
  logic [31:0] limit;
  logic [32:0] top_base;

  // raster cursor and running row base
  logic [16:0] cursor_column;
  logic [16:0] cursor_row;
  logic [32:0] row_base;
  logic [16:0] cursor_column_next;
  logic [16:0] cursor_row_next;
  logic [32:0] row_base_next;

  // input stage and result register
  logic stg_valid;
  req_t stg;
  rgb_t pal_rd;
  logic res_valid;
  res_t res_data;
  res_t res_next;

  logic stg_adv;
  logic accept;
  logic pal_wr;

  logic [33:0] addr_sum;
  logic [17:0] col_inc;
  logic [16:0] right_edge;
  logic        drop;
  logic        is_transparent;
  logic        in_palette;

  // handshake
  assign stg_adv   = stg_valid && (!res_valid || res.ready);
  assign req.ready = !stg_valid || stg_adv;
  assign accept    = req.valid && req.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width      <= '0;
      screen_height     <= '0;
      image_left        <= '0;
      image_top         <= '0;
      image_width       <= '0;
      transparent_index <= TRANSPARENT_NONE;
      palette_size      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:      screen_width      <= cfg_data;
        REG_SCREEN_HEIGHT:     screen_height     <= cfg_data;
        REG_IMAGE_LEFT:        image_left        <= cfg_data;
        REG_IMAGE_TOP:         image_top         <= cfg_data;
        REG_IMAGE_WIDTH:       image_width       <= cfg_data;
        REG_TRANSPARENT_INDEX: transparent_index <= cfg_data[8:0];
        REG_PALETTE_SIZE:      palette_size      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // screen size and top-of-image row base
  always_ff @(posedge clk) begin
    limit    <= 32'(screen_width) * 32'(screen_height);
    top_base <= 33'(image_top) * 33'(screen_width);
  end

  // palette: written when a palette transaction leaves the input stage
  assign pal_wr = stg_adv && (stg.req_type == REQ_PALETTE) &&
                  ({1'b0, stg.color_index} < DEPTH_LIM);

  gfpp_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (stg.color_index[IDX_W-1:0]),
    .wr_data ({stg.entry_red, stg.entry_green, stg.entry_blue}),
    .rd_en   (accept),
    .rd_addr (req.data.color_index[IDX_W-1:0]),
    .rd_data (pal_rd)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.ready) begin
      stg_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg <= req.data;
    end
  end

  // per-pixel address, wrap and colour
  assign addr_sum       = {1'b0, row_base} + 34'(cursor_column);
  assign col_inc        = {1'b0, cursor_column} + 18'd1;
  assign right_edge     = {1'b0, image_left} + {1'b0, image_width};
  assign drop           = addr_sum >= 34'(limit);
  assign is_transparent = !transparent_index[8] &&
                          (stg.color_index == transparent_index[7:0]);
  assign in_palette     = ({1'b0, stg.color_index} < palette_size) &&
                          ({1'b0, stg.color_index} < DEPTH_LIM);

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    row_base_next      = row_base;
    res_next           = '0;
    case (req_kind_t'(stg.req_type))
      REQ_START: begin
        cursor_column_next = {1'b0, image_left};
        cursor_row_next    = {1'b0, image_top};
        row_base_next      = top_base;
      end
      REQ_PIXEL: begin
        if (!drop) begin
          if (col_inc >= {1'b0, right_edge}) begin
            // wrap to the left edge of the next row
            cursor_column_next = {1'b0, image_left};
            cursor_row_next    = cursor_row + 17'd1;
            row_base_next      = (cursor_row == '1) ? '0 :
                                 row_base + 33'(screen_width);
          end else begin
            cursor_column_next = col_inc[16:0];
          end
          if (!is_transparent) begin
            res_next.write_enable  = 1'b1;
            res_next.pixel_address = addr_sum[31:0];
            if (in_palette) begin
              res_next.pixel_red   = pal_rd[23:16];
              res_next.pixel_green = pal_rd[15:8];
              res_next.pixel_blue  = pal_rd[7:0];
              res_next.pixel_alpha = 8'hFF;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // cursor; row base re-derived while the stage is empty so that a new
  // screen width takes effect before the next transaction is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      row_base      <= '0;
    end else if (stg_adv) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      row_base      <= row_base_next;
    end else if (!stg_valid) begin
      row_base      <= 33'(cursor_row) * 33'(screen_width);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stg_adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      res_data <= res_next;
    end
  end

  // checks
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.write_enable |-> res_data.pixel_address == '0 &&
    res_data.pixel_alpha == '0)
    else $error("result without write carries a non-zero payload");

  a_drop_freeze: assert property (@(posedge clk) disable iff (rst)
    stg_adv && stg.req_type == REQ_PIXEL && drop |=>
    $stable(cursor_column) && $stable(cursor_row) && !res_data.write_enable)
    else $error("dropped pixel moved the cursor or was written");

  a_start_cursor: assert property (@(posedge clk) disable iff (rst)
    stg_adv && stg.req_type == REQ_START |=>
    cursor_column == 17'($past(image_left)) && cursor_row == 17'($past(image_top)))
    else $error("start did not place the cursor at the image origin");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !stg_adv |=> stg_valid && $stable(cursor_row) && $stable(row_base))
    else $error("stalled stage lost its transaction or moved the cursor");

endmodule

### bench/gfpp_frame_checker.sv
// ---------------------------------------------------------------------------
// gfpp_frame_checker: scoreboard for the GIF frame pixel placer
// Follows configuration writes and accepted requests, predicts the frame
// buffer write that each request causes and compares it with the results.
// ---------------------------------------------------------------------------
module gfpp_frame_checker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gfpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gfpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  gfpp_req_if                              req_mon,
  gfpp_res_if                              res_mon,
  output int                               fail_count,
  output int                               pending
);
  import gfpp_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // shadow of the placer state and its registers
  rgb_t        palette_copy [256];
  logic [16:0] col_pos;
  logic [16:0] row_pos;
  logic [15:0] scr_w;
  logic [15:0] scr_h;
  logic [15:0] img_left;
  logic [15:0] img_top;
  logic [15:0] img_w;
  logic [8:0]  trans_idx;
  logic [8:0]  pal_size;

  res_t frame_write_q [$];
  res_t expected_write;
  res_t seen_write;

  // advance the shadow state by one request, return the frame write it causes
  function automatic res_t next_frame_write(req_t r);
    res_t        w;
    logic [63:0] addr;
    logic [63:0] limit;
    logic [17:0] right;
    rgb_t        entry;
    w = '0;
    case (r.req_type)
      REQ_PALETTE: begin
        if (9'(r.color_index) < PALETTE_DEPTH)
          palette_copy[r.color_index] = {r.entry_red, r.entry_green, r.entry_blue};
      end
      REQ_START: begin
        col_pos = 17'(img_left);
        row_pos = 17'(img_top);
      end
      REQ_PIXEL: begin
        addr  = 64'(row_pos) * 64'(scr_w) + 64'(col_pos);
        limit = 64'(scr_w) * 64'(scr_h);
        // screen full: drop and keep the cursor where it is
        if (addr < limit) begin
          right = 18'(img_left) + 18'(img_w);
          if (18'(col_pos) + 18'd1 >= right) begin
            col_pos = 17'(img_left);
            row_pos = row_pos + 17'd1;
          end else begin
            col_pos = col_pos + 17'd1;
          end
          // transparent pixels move the cursor but are not written
          if (!(trans_idx < TRANSPARENT_NONE && 9'(r.color_index) == trans_idx)) begin
            w.write_enable  = 1'b1;
            w.pixel_address = addr[31:0];
            // bad index leaves transparent black
            if (9'(r.color_index) < pal_size && 9'(r.color_index) < PALETTE_DEPTH) begin
              entry = palette_copy[r.color_index];
              {w.pixel_red, w.pixel_green, w.pixel_blue} = entry;
              w.pixel_alpha = 8'hFF;
            end
          end
        end
      end
      default: ;  // unknown request kind: no effect
    endcase
    return w;
  endfunction

  task automatic flag_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("frame check: %s", msg);
  endtask

  // monitor: registers, requests, results
  always @(posedge clk) begin
    if (rst) begin
      col_pos    = '0;
      row_pos    = '0;
      scr_w      = '0;
      scr_h      = '0;
      img_left   = '0;
      img_top    = '0;
      img_w      = '0;
      trans_idx  = TRANSPARENT_NONE;
      pal_size   = '0;
      fail_count = 0;
      frame_write_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:      scr_w     = cfg_data;
          REG_SCREEN_HEIGHT:     scr_h     = cfg_data;
          REG_IMAGE_LEFT:        img_left  = cfg_data;
          REG_IMAGE_TOP:         img_top   = cfg_data;
          REG_IMAGE_WIDTH:       img_w     = cfg_data;
          REG_TRANSPARENT_INDEX: trans_idx = cfg_data[8:0];
          REG_PALETTE_SIZE:      pal_size  = cfg_data[8:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        frame_write_q.insert(frame_write_q.size(), next_frame_write(req_mon.data));
      if (res_mon.valid && res_mon.ready) begin
        seen_write = res_mon.data;
        if (frame_write_q.size() == 0) begin
          flag_failure($sformatf("unexpected result we=%0b addr=%h rgba=%h_%h_%h_%h",
                                 seen_write.write_enable, seen_write.pixel_address,
                                 seen_write.pixel_red, seen_write.pixel_green,
                                 seen_write.pixel_blue, seen_write.pixel_alpha));
        end else begin
          expected_write = frame_write_q.pop_front();
          if (seen_write.write_enable  !== expected_write.write_enable  ||
              seen_write.pixel_address !== expected_write.pixel_address ||
              seen_write.pixel_red     !== expected_write.pixel_red     ||
              seen_write.pixel_green   !== expected_write.pixel_green   ||
              seen_write.pixel_blue    !== expected_write.pixel_blue    ||
              seen_write.pixel_alpha   !== expected_write.pixel_alpha) begin
            flag_failure($sformatf(
              "mismatch exp we=%0b addr=%h rgba=%h_%h_%h_%h got we=%0b addr=%h rgba=%h_%h_%h_%h",
              expected_write.write_enable, expected_write.pixel_address,
              expected_write.pixel_red, expected_write.pixel_green,
              expected_write.pixel_blue, expected_write.pixel_alpha,
              seen_write.write_enable, seen_write.pixel_address,
              seen_write.pixel_red, seen_write.pixel_green,
              seen_write.pixel_blue, seen_write.pixel_alpha));
          end
        end
      end
    end
    pending <= frame_write_q.size();
  end

endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the GIF frame pixel placer
// Directed palette, raster, wrap, screen-full and transparency cases, then
// random image phases under changing screen setups with random stalls on
// both channels; checking is done by the frame checker beside the block.
// ---------------------------------------------------------------------------
module testbench;
  import gfpp_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_PERCENT = 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [15:0] image_left;
    logic [15:0] image_top;
    logic [15:0] image_width;
    logic [8:0]  transparent;
    logic [8:0]  palette_size;
  } frame_setup_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;
  int                     idle_cycles = 0;
  int                     items_sent = 0;
  bit                     no_idle = 1'b0;
  bit                     loaded [256];
  frame_setup_t           cur_setup;

  gfpp_req_if req_ch ();
  gfpp_res_if res_ch ();

  gif_frame_pixel_placer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  gfpp_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // result side: random back-pressure
  always @(posedge clk) begin
    res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[gif_frame_pixel_placer] ERROR");
      $finish;
    end
  end

  function automatic req_t build_req(logic [1:0] kind, logic [7:0] slot, rgb_t colour);
    req_t r;
    r.req_type    = kind;
    r.color_index = slot;
    {r.entry_red, r.entry_green, r.entry_blue} = colour;
    return r;
  endfunction

  // one request transaction, with a random gap in front
  task automatic send_req(req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // never let a pixel read a palette slot that was not loaded
  task automatic issue(req_t r);
    if (r.req_type == REQ_PIXEL && 9'(r.color_index) < cur_setup.palette_size &&
        !loaded[r.color_index]) begin
      send_req(build_req(REQ_PALETTE, r.color_index, rgb_t'($urandom)));
      loaded[r.color_index] = 1'b1;
    end
    if (r.req_type == REQ_PALETTE)
      loaded[r.color_index] = 1'b1;
    send_req(r);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic apply_setup(frame_setup_t s);
    settle();
    put_reg(REG_SCREEN_WIDTH, s.screen_width);
    put_reg(REG_SCREEN_HEIGHT, s.screen_height);
    put_reg(REG_IMAGE_LEFT, s.image_left);
    put_reg(REG_IMAGE_TOP, s.image_top);
    put_reg(REG_IMAGE_WIDTH, s.image_width);
    put_reg(REG_TRANSPARENT_INDEX, 16'(s.transparent));
    put_reg(REG_PALETTE_SIZE, 16'(s.palette_size));
    cfg_we <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    cur_setup = s;
  endtask

  function automatic frame_setup_t random_setup();
    frame_setup_t s;
    int           mode;
    mode = $urandom_range(9);
    case (mode)
      0: begin  // bottom-right corner of the largest screen
        s.screen_width  = 16'hFFFF;
        s.screen_height = 16'hFFFF;
        s.image_top     = ($urandom_range(2) == 0) ? 16'hFFFF : 16'hFFFE;
        s.image_left    = 16'hFFFF - 16'($urandom_range(8));
        s.image_width   = 16'($urandom_range(10));
      end
      1: begin  // empty screen
        s.screen_width  = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 20));
        s.screen_height = (s.screen_width == 0) ? 16'($urandom_range(10)) : 16'd0;
        s.image_left    = 16'($urandom_range(4));
        s.image_top     = 16'($urandom_range(4));
        s.image_width   = 16'($urandom_range(6));
      end
      2: begin  // wide image rectangle, columns run past the screen edge
        s.screen_width  = 16'hFFFF;
        s.screen_height = 16'hFFFF;
        s.image_left    = 16'hFFFF;
        s.image_top     = 16'($urandom_range(3));
        s.image_width   = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
      end
      default: begin
        s.screen_width  = 16'($urandom_range(1, 20));
        s.screen_height = 16'($urandom_range(1, 10));
        s.image_left    = 16'($urandom_range(0, s.screen_width + 1));
        s.image_top     = 16'($urandom_range(0, s.screen_height));
        s.image_width   = 16'($urandom_range(0, s.screen_width));
      end
    endcase
    case ($urandom_range(3))
      0:       s.transparent = TRANSPARENT_NONE;
      1:       s.transparent = $urandom_range(1) ? 9'd0 : 9'd255;
      default: s.transparent = 9'($urandom_range(255));
    endcase
    case ($urandom_range(4))
      0:       s.palette_size = 9'd0;
      1:       s.palette_size = 9'd256;
      default: s.palette_size = 9'($urandom_range(1, 256));
    endcase
    return s;
  endfunction

  // mostly pixel streams, with palette loads, restarts and some noise
  function automatic req_t random_req();
    req_t        r;
    logic [63:0] noise;
    int          roll;
    int          sel;
    roll = $urandom_range(99);
    r    = build_req(REQ_PIXEL, 8'($urandom), rgb_t'($urandom));
    if (roll < 70) begin
      sel = $urandom_range(9);
      if (sel < 5 && cur_setup.palette_size != 0)
        r.color_index = 8'($urandom_range(cur_setup.palette_size - 1));
      else if (sel < 7 && cur_setup.transparent < TRANSPARENT_NONE)
        r.color_index = cur_setup.transparent[7:0];
      else if (sel == 9 && cur_setup.palette_size < 256)
        r.color_index = 8'($urandom_range(cur_setup.palette_size, 255));
    end else if (roll < 80) begin
      r.req_type = REQ_PALETTE;
    end else if (roll < 85) begin
      r.req_type = REQ_START;
    end else if (roll < 88) begin
      r.req_type = REQ_UNUSED;
    end else begin
      noise = {$urandom, $urandom};
      r     = noise[$bits(req_t)-1:0];
    end
    return r;
  endfunction

  initial begin
    frame_setup_t s;
    int           len;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // small screen: wrap, transparency, bad index, screen full, unknown kind
    s = '{16'd4, 16'd2, 16'd1, 16'd0, 16'd2, 9'd2, 9'd3};
    apply_setup(s);
    issue(build_req(REQ_PALETTE, 8'd0, 24'h000000));
    issue(build_req(REQ_PALETTE, 8'd255, 24'hFFFFFF));
    issue(build_req(REQ_PALETTE, 8'd1, 24'hA55AC3));
    issue(build_req(REQ_PALETTE, 8'd2, 24'h123456));
    issue(build_req(REQ_START, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd0, 24'hFFFFFF));
    issue(build_req(REQ_PIXEL, 8'd255, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd2, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd0, 24'h000000));
    issue(build_req(REQ_UNUSED, 8'hFF, 24'hFFFFFF));
    issue(build_req(REQ_START, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));

    // largest screen, full palette, no transparency: address runs into the limit
    s = '{16'hFFFF, 16'hFFFF, 16'hFFFD, 16'hFFFE, 16'd3, TRANSPARENT_NONE, 9'd256};
    apply_setup(s);
    issue(build_req(REQ_START, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd255, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));

    // zero screen width: nothing fits
    s = '{16'd0, 16'd5, 16'd0, 16'd0, 16'd2, 9'd1, 9'd0};
    apply_setup(s);
    issue(build_req(REQ_START, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));

    // zero image width: every pixel steps down a row
    s = '{16'd5, 16'd5, 16'd1, 16'd0, 16'd0, 9'd0, 9'd2};
    apply_setup(s);
    issue(build_req(REQ_START, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd0, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));
    issue(build_req(REQ_PIXEL, 8'd1, 24'h000000));

    // random image phases
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (items_sent >= 600 && items_sent < 900);
      apply_setup(random_setup());
      if ($urandom_range(9) != 0)
        issue(build_req(REQ_START, 8'($urandom), rgb_t'($urandom)));
      len = $urandom_range(40, 160);
      repeat (len) issue(random_req());
    end
    no_idle = 1'b0;

    settle();
    if (fail_count == 0 && pending == 0)
      $display("[gif_frame_pixel_placer] OK");
    else
      $display("[gif_frame_pixel_placer] ERROR");
    $finish;
  end

endmodule
